// File: design/data_stack_with_roll_defines.svh
// Assertion helpers used by the file that checks the stack's own logic.
`ifndef DATA_STACK_WITH_ROLL_DEFINES_SVH
`define DATA_STACK_WITH_ROLL_DEFINES_SVH

// Same-cycle implication, switched off while reset is asserted.
`define DSWR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("data stack: same-cycle check failed");

// Next-cycle implication, switched off while reset is asserted.
`define DSWR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("data stack: next-cycle check failed");

`endif

// File: design/dswr_pkg.sv
`timescale 1ns / 1ps

package dswr_pkg;

  localparam int DATA_W  = 32;
  localparam int OP_W    = 3;
  localparam int POS_W   = 6;
  localparam int ST_W    = 2;
  localparam int DEPTH_W = 6;

  typedef logic [DATA_W-1:0] word_t;

  localparam logic [OP_W-1:0] OP_PUSH  = 3'd0;
  localparam logic [OP_W-1:0] OP_POP   = 3'd1;
  localparam logic [OP_W-1:0] OP_SWAP  = 3'd2;
  localparam logic [OP_W-1:0] OP_ROLL  = 3'd3;
  localparam logic [OP_W-1:0] OP_ADD   = 3'd4;
  localparam logic [OP_W-1:0] OP_PRINT = 3'd5;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_UNDER = 2'd1;
  localparam logic [ST_W-1:0] ST_OVER  = 2'd2;
  localparam logic [ST_W-1:0] ST_ROLL  = 2'd3;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t op;
    word_t   a;
    word_t   b;
  } alu_req_t;

endpackage

// File: design/dswr_alu.sv
`timescale 1ns / 1ps

// Shared adder/subtractor used for both word sums and index stepping.
module dswr_alu (
  input  dswr_pkg::alu_req_t req,
  output dswr_pkg::word_t    res
);
  import dswr_pkg::*;

  always_comb begin
    case (req.op)
      ALU_ADD: res = req.a + req.b;
      ALU_SUB: res = req.a - req.b;
      default: res = req.a + req.b;
    endcase
  end

endmodule

// File: design/dswr_ram.sv
`timescale 1ns / 1ps

// Stack storage: one write port, one read port with registered data.
module dswr_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  dswr_pkg::word_t   wdata,
  input  logic [AW-1:0]     raddr,
  output dswr_pkg::word_t   rdata
);
  import dswr_pkg::*;

  word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/data_stack_with_roll.sv
// Bounded stack of signed 32-bit words, driven one operation per input beat.
// Input channel (in_valid/in_ready) carries op, value and position; output
// channel (out_valid/out_ready) carries data, status, depth_now and last.
// Every operation yields one result beat, except print, which yields one beat
// per element from top to bottom (one beat with data zero on an empty stack),
// with last marking the final beat of the item.
// Operations are run by a small sequencer around one shared adder and a
// single-port-read stack memory whose read data is registered, so each step
// waits for its read. Roll and swap move each word below the old top up one
// place, reading it in one state and writing it in the next. The block takes
// one item at a time, but a finished result sits in the output register, so
// the next item is accepted while it waits. If the receiver stalls, the
// sequencer holds in its result or print state until the output register is
// free; nothing is lost. Synchronous reset empties the stack and drops any
// pending result; the memory itself is not cleared.
`timescale 1ns / 1ps
`include "data_stack_with_roll_defines.svh"

module data_stack_with_roll #(
  parameter int STACK_DEPTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [dswr_pkg::OP_W-1:0]           in_op,
  input  logic signed [dswr_pkg::DATA_W-1:0]  in_value,
  input  logic [dswr_pkg::POS_W-1:0]          in_position,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [dswr_pkg::DATA_W-1:0]  out_data,
  output logic [dswr_pkg::ST_W-1:0]           out_status,
  output logic [dswr_pkg::DEPTH_W-1:0]        out_depth_now,
  output logic                                out_last
);
  import dswr_pkg::*;

  // Index width covers the entries; the count must also hold the capacity.
  localparam int IDX_W = $clog2(STACK_DEPTH);
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_ROLL_T,
    S_ROLL_SAVE,
    S_ROLL_RD,
    S_ROLL_WR,
    S_ADD_B,
    S_ADD_S,
    S_PR_EMIT,
    S_RDTOP,
    S_RES
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [OP_W-1:0]     op_r, op_nxt;
  word_t               val_r, val_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [ST_W-1:0]     st_r, st_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [IDX_W-1:0]    dst_r, dst_nxt;
  word_t               tmp_r, tmp_nxt;

  logic                out_valid_r, out_valid_nxt;
  word_t               out_data_r, out_data_nxt;
  logic [ST_W-1:0]     out_status_r, out_status_nxt;
  logic [DEPTH_W-1:0]  out_depth_r, out_depth_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_load;
  logic                slot_free;

  alu_req_t            alu_req;
  word_t               alu_res;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  word_t               ram_wdata;
  logic [IDX_W-1:0]    ram_raddr;
  word_t               ram_rdata;

  logic [POS_W-1:0]    pos_eff;
  logic [CMP_W-1:0]    cnt_cmp;
  logic [CMP_W-1:0]    pos_cmp;
  logic                full;
  logic                empty;
  logic                below_two;

  dswr_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  dswr_ram #(
    .DEPTH (STACK_DEPTH),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Swap is a roll to the second position.
  assign pos_eff   = (op_r == OP_SWAP) ? POS_W'(2) : pos_r;
  assign cnt_cmp   = CMP_W'(cnt_r);
  assign pos_cmp   = CMP_W'(pos_eff);
  assign full      = (cnt_r == CNT_W'(STACK_DEPTH));
  assign empty     = (cnt_r == '0);
  assign below_two = (cnt_r < CNT_W'(2));
  assign slot_free = !out_valid_r || out_ready;

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_data      = $signed(out_data_r);
  assign out_status    = out_status_r;
  assign out_depth_now = out_depth_r;
  assign out_last      = out_last_r;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    op_nxt         = op_r;
    val_nxt        = val_r;
    pos_nxt        = pos_r;
    st_nxt         = st_r;
    idx_nxt        = idx_r;
    dst_nxt        = dst_r;
    tmp_nxt        = tmp_r;
    out_load       = 1'b0;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_depth_nxt  = out_depth_r;
    out_last_nxt   = out_last_r;
    alu_req        = '{op: ALU_SUB, a: DATA_W'(cnt_r), b: DATA_W'(1)};
    ram_we         = 1'b0;
    ram_waddr      = idx_r;
    ram_wdata      = tmp_r;
    ram_raddr      = idx_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_op;
          val_nxt   = $unsigned(in_value);
          pos_nxt   = in_position;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        st_nxt    = ST_OK;
        state_nxt = S_RDTOP;
        case (op_r)
          OP_PUSH: begin
            if (full) begin
              st_nxt = ST_OVER;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = cnt_r[IDX_W-1:0];
              ram_wdata = val_r;
              alu_req   = '{op: ALU_ADD, a: DATA_W'(cnt_r), b: DATA_W'(1)};
              cnt_nxt   = alu_res[CNT_W-1:0];
            end
          end
          OP_POP: begin
            if (empty) begin
              st_nxt = ST_UNDER;
            end else begin
              cnt_nxt = alu_res[CNT_W-1:0];
            end
          end
          OP_SWAP, OP_ROLL: begin
            if (op_r == OP_SWAP && below_two) begin
              st_nxt = ST_UNDER;
            end else if (pos_cmp <= CMP_W'(1)) begin
              st_nxt = ST_OK;
            end else if (pos_cmp > cnt_cmp) begin
              st_nxt = ST_ROLL;
            end else begin
              // Destination index of the old top word.
              alu_req   = '{op: ALU_SUB, a: DATA_W'(cnt_r), b: DATA_W'(pos_eff)};
              dst_nxt   = alu_res[IDX_W-1:0];
              state_nxt = S_ROLL_T;
            end
          end
          OP_ADD: begin
            if (below_two) begin
              st_nxt = ST_UNDER;
            end else begin
              ram_raddr = alu_res[IDX_W-1:0];
              idx_nxt   = alu_res[IDX_W-1:0];
              state_nxt = S_ADD_B;
            end
          end
          OP_PRINT: begin
            if (!empty) begin
              ram_raddr = alu_res[IDX_W-1:0];
              idx_nxt   = alu_res[IDX_W-1:0];
              state_nxt = S_PR_EMIT;
            end
          end
          default: begin
            st_nxt = ST_OK;
          end
        endcase
      end

      S_ROLL_T: begin
        ram_raddr = alu_res[IDX_W-1:0];
        idx_nxt   = alu_res[IDX_W-1:0];
        state_nxt = S_ROLL_SAVE;
      end

      S_ROLL_SAVE: begin
        tmp_nxt   = ram_rdata;
        state_nxt = S_ROLL_RD;
      end

      S_ROLL_RD: begin
        if (idx_r == dst_r) begin
          ram_we    = 1'b1;
          ram_waddr = dst_r;
          ram_wdata = tmp_r;
          state_nxt = S_RDTOP;
        end else begin
          alu_req   = '{op: ALU_SUB, a: DATA_W'(idx_r), b: DATA_W'(1)};
          ram_raddr = alu_res[IDX_W-1:0];
          state_nxt = S_ROLL_WR;
        end
      end

      S_ROLL_WR: begin
        // The word below moves up one place.
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = ram_rdata;
        alu_req   = '{op: ALU_SUB, a: DATA_W'(idx_r), b: DATA_W'(1)};
        idx_nxt   = alu_res[IDX_W-1:0];
        state_nxt = S_ROLL_RD;
      end

      S_ADD_B: begin
        tmp_nxt   = ram_rdata;
        alu_req   = '{op: ALU_SUB, a: DATA_W'(idx_r), b: DATA_W'(1)};
        ram_raddr = alu_res[IDX_W-1:0];
        idx_nxt   = alu_res[IDX_W-1:0];
        cnt_nxt   = CNT_W'(idx_r);
        state_nxt = S_ADD_S;
      end

      S_ADD_S: begin
        alu_req   = '{op: ALU_ADD, a: tmp_r, b: ram_rdata};
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = alu_res;
        state_nxt = S_RDTOP;
      end

      S_PR_EMIT: begin
        if (slot_free) begin
          out_load       = 1'b1;
          out_data_nxt   = ram_rdata;
          out_status_nxt = ST_OK;
          out_depth_nxt  = cnt_cmp[DEPTH_W-1:0];
          out_last_nxt   = (idx_r == '0);
          if (idx_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            alu_req   = '{op: ALU_SUB, a: DATA_W'(idx_r), b: DATA_W'(1)};
            ram_raddr = alu_res[IDX_W-1:0];
            idx_nxt   = alu_res[IDX_W-1:0];
          end
        end
      end

      S_RDTOP: begin
        ram_raddr = alu_res[IDX_W-1:0];
        state_nxt = S_RES;
      end

      S_RES: begin
        // Keep the read address so the top word stays on the read port.
        ram_raddr = alu_res[IDX_W-1:0];
        if (slot_free) begin
          out_load       = 1'b1;
          out_data_nxt   = empty ? '0 : ram_rdata;
          out_status_nxt = st_r;
          out_depth_nxt  = cnt_cmp[DEPTH_W-1:0];
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Payload registers carry no reset; control state and the output valid do.
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    val_r        <= val_nxt;
    pos_r        <= pos_nxt;
    st_r         <= st_nxt;
    idx_r        <= idx_nxt;
    dst_r        <= dst_nxt;
    tmp_r        <= tmp_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    out_depth_r  <= out_depth_nxt;
    out_last_r   <= out_last_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The element count never exceeds the capacity.
  `DSWR_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CNT_W'(STACK_DEPTH))

  // A new result is only loaded when the previous beat has gone or is going.
  `DSWR_ASSERT_IMP(a_no_overwrite, clk, rst_n, out_load && out_valid_r, out_ready)

  // Only the final beat of an item can carry an error status.
  `DSWR_ASSERT_IMP(a_mid_beat_ok, clk, rst_n, out_valid_r && !out_last_r,
                   out_status_r == ST_OK)

  // The count moves by at most one per cycle.
  `DSWR_ASSERT_NXT(a_cnt_step, clk, rst_n, 1'b1,
                   !$past(rst_n) || (cnt_r == $past(cnt_r)) ||
                   (cnt_r == $past(cnt_r) + 1'b1) || (cnt_r == $past(cnt_r) - 1'b1))

endmodule
